>>> hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; compiled first, used by the channel interfaces and the core.

package u8d_pkg;

  // Field widths of the two channels and of the count of continuation bytes due.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned DUE_W  = 3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_CHAR     = 3'd0,
    ST_END      = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_BAD_CONT = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  // Continuation byte form: 10xxxxxx.
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

endpackage

>>> hdl/u8d_in_if.sv
// Input channel of the UTF-8 stream decoder: one raw byte per transfer.
// Depends on u8d_pkg for the field widths.

interface u8d_in_if
  import u8d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> hdl/u8d_out_if.sv
// Result channel of the UTF-8 stream decoder: one decoded result per transfer.
// Depends on u8d_pkg for the field widths.

interface u8d_out_if
  import u8d_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic [2:0]      status;
  logic            string_done;

  modport source (output valid, output code_point, output status, output string_done,
                  input ready);
  modport sink   (input valid, input code_point, input status, input string_done,
                  output ready);
endinterface

>>> hdl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder, top level: input register, decode logic, result register.
// Depends on u8d_pkg, u8d_in_if and u8d_out_if.
//
// The decoder takes one byte per transfer and sustains one byte per clock cycle
// whenever the result side keeps up. A byte taken into the input register is
// decoded against the partial code point, the count of continuation bytes still
// due and the discard flag, and its result (if any) is loaded into the result
// register once that register is free or being drained. Lead bytes, continuation
// bytes in the middle of a sequence and bytes being discarded after an error or
// NUL give no result, unless a lead or continuation byte ends the buffer early
// (truncation). Input ready follows output ready combinationally, so a full result
// register that is drained in the same cycle never stalls the input; the decoder
// state is a single register loop updated once per byte.

module utf8_stream_decoder_core
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_chan,
  u8d_out_if.source out_chan
);

  // Input register.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eob_r;

  // Decoder state.
  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [DUE_W-1:0] due_r, due_nxt;
  logic             discard_r, discard_nxt;

  // Result register.
  logic            out_valid_r;
  logic [CP_W-1:0] out_cp_r;
  status_t         out_status_r;
  logic            out_done_r;

  // Decode results for the byte in the input register.
  logic            res_valid;
  logic [CP_W-1:0] res_cp;
  status_t         res_status;
  logic            res_done;
  logic            lead_ok;
  logic [CP_W-1:0] lead_val;
  logic [DUE_W-1:0] lead_due;
  logic            proc;
  logic            in_ready;

  // The held byte is consumed when the result register is free or being drained.
  assign proc     = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || proc;
  assign in_chan.ready = in_ready;

  // Lead byte forms of two to six octets.
  always_comb begin
    lead_ok  = 1'b1;
    lead_val = '0;
    lead_due = '0;
    unique casez (in_byte_r)
      8'b110?????: begin
        lead_val = {{(CP_W-5){1'b0}}, in_byte_r[4:0]};
        lead_due = DUE_W'(1);
      end
      8'b1110????: begin
        lead_val = {{(CP_W-4){1'b0}}, in_byte_r[3:0]};
        lead_due = DUE_W'(2);
      end
      8'b11110???: begin
        lead_val = {{(CP_W-3){1'b0}}, in_byte_r[2:0]};
        lead_due = DUE_W'(3);
      end
      8'b111110??: begin
        lead_val = {{(CP_W-2){1'b0}}, in_byte_r[1:0]};
        lead_due = DUE_W'(4);
      end
      8'b1111110?: begin
        lead_val = {{(CP_W-1){1'b0}}, in_byte_r[0]};
        lead_due = DUE_W'(5);
      end
      default: begin
        lead_ok = 1'b0;
      end
    endcase
  end

  // Next state and result for one byte.
  always_comb begin
    partial_nxt = partial_r;
    due_nxt     = due_r;
    discard_nxt = discard_r;
    res_valid   = 1'b0;
    res_cp      = '0;
    res_status  = ST_CHAR;
    res_done    = 1'b0;

    if (discard_r) begin
      // Skip bytes until the end of the buffer.
      if (in_eob_r) begin
        discard_nxt = 1'b0;
      end
    end else if (due_r == '0) begin
      // Character boundary.
      if (in_byte_r == '0) begin
        res_valid   = 1'b1;
        res_status  = ST_END;
        res_done    = 1'b1;
        partial_nxt = '0;
        discard_nxt = !in_eob_r;
      end else if (!in_byte_r[7]) begin
        res_valid  = 1'b1;
        res_cp     = {{(CP_W-BYTE_W){1'b0}}, in_byte_r};
        res_done   = in_eob_r;
      end else if (!lead_ok) begin
        res_valid   = 1'b1;
        res_status  = ST_BAD_LEAD;
        res_done    = 1'b1;
        partial_nxt = '0;
        discard_nxt = !in_eob_r;
      end else if (in_eob_r) begin
        res_valid   = 1'b1;
        res_status  = ST_TRUNC;
        res_done    = 1'b1;
        partial_nxt = '0;
      end else begin
        partial_nxt = lead_val;
        due_nxt     = lead_due;
      end
    end else if ((in_byte_r & CONT_MASK) != CONT_TAG) begin
      // Not a continuation byte while one is due.
      res_valid   = 1'b1;
      res_status  = ST_BAD_CONT;
      res_done    = 1'b1;
      partial_nxt = '0;
      due_nxt     = '0;
      discard_nxt = !in_eob_r;
    end else if (due_r == DUE_W'(1)) begin
      // Last continuation byte completes the code point.
      res_valid   = 1'b1;
      res_cp      = {partial_r[CP_W-7:0], in_byte_r[5:0]};
      res_done    = in_eob_r;
      partial_nxt = '0;
      due_nxt     = '0;
    end else if (in_eob_r) begin
      res_valid   = 1'b1;
      res_status  = ST_TRUNC;
      res_done    = 1'b1;
      partial_nxt = '0;
      due_nxt     = '0;
    end else begin
      partial_nxt = {partial_r[CP_W-7:0], in_byte_r[5:0]};
      due_nxt     = due_r - DUE_W'(1);
    end
  end

  // Control registers: valid flags and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      partial_r   <= '0;
      due_r       <= '0;
      discard_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (proc) begin
        out_valid_r <= res_valid;
        partial_r   <= partial_nxt;
        due_r       <= due_nxt;
        discard_r   <= discard_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load on a transfer in or a new result.
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_eob_r  <= in_chan.end_of_buffer;
    end
    if (proc && res_valid) begin
      out_cp_r     <= res_cp;
      out_status_r <= res_status;
      out_done_r   <= res_done;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.code_point  = out_cp_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.string_done = out_done_r;

  // A sequence in progress and discarding never coexist.
  a_due_not_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (due_r != '0) |-> !discard_r)
    else $error("continuation bytes due while discarding");

  // Every result other than a character closes the string.
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_CHAR) |-> out_done_r)
    else $error("non-character result without string_done");

  // Non-character results carry no code point.
  a_err_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_CHAR) |-> (out_cp_r == '0))
    else $error("non-character result with a code point");

  // Discarding starts only after an error or NUL result.
  a_discard_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(discard_r) |-> (out_valid_r && (out_status_r == ST_END ||
      out_status_r == ST_BAD_LEAD || out_status_r == ST_BAD_CONT)))
    else $error("discard entered without an error result");

endmodule
